FILE: design/cpt_pkg.sv
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared types, codes and tables for the cascaded prescaled timer bank.
// ----------------------------------------------------------------------------
package cpt_pkg;

   localparam int NUM_TIMERS_DEFAULT = 4;
   localparam int IDX_W              = 2;
   localparam int DATA_W             = 16;
   localparam int IRQ_W              = 4;
   localparam int PRESCALE_W         = 10;
   localparam int LIMIT_W            = PRESCALE_W + 1;

   localparam int CTRL_CASCADE_BIT = 2;
   localparam int CTRL_IRQ_BIT     = 6;
   localparam int CTRL_ENABLE_BIT  = 7;

   localparam logic [DATA_W-1:0] COUNT_MAX = 16'hFFFF;

   typedef enum logic [1:0] {
      MODE_TICK    = 2'd0,
      MODE_CONTROL = 2'd1,
      MODE_RELOAD  = 2'd2,
      MODE_READ    = 2'd3
   } mode_type;

   typedef struct packed {
      logic       enable;
      logic       irq;
      logic       cascade;
      logic [1:0] prescale;
   } ctrl_type;

   typedef struct packed {
      mode_type          mode;
      logic [IDX_W-1:0]  timer_index;
      logic [DATA_W-1:0] write_data;
   } req_type;

   typedef struct packed {
      logic [IRQ_W-1:0]  irq_pulses;
      logic [DATA_W-1:0] read_value;
   } rsp_type;

   function automatic logic [LIMIT_W-1:0] prescale_limit(input logic [1:0] sel);
      logic [LIMIT_W-1:0] lim;
      case (sel)
         2'd0:    lim = 11'd1;
         2'd1:    lim = 11'd64;
         2'd2:    lim = 11'd256;
         default: lim = 11'd1024;
      endcase
      return lim;
   endfunction

endpackage

FILE: design/cpt_bank.sv
// ----------------------------------------------------------------------------
// cpt_bank
// Timer state and the single-pass update for one request: tick with
// prescale and cascade ripple, control write, reload write, counter read.
// ----------------------------------------------------------------------------
module cpt_bank #(
   parameter int NUM_TIMERS = cpt_pkg::NUM_TIMERS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             go,
   input  cpt_pkg::req_type req,
   output cpt_pkg::rsp_type rsp
);

   localparam int IrqBits = cpt_pkg::IRQ_W;

   logic [cpt_pkg::DATA_W-1:0]     counter_ff   [NUM_TIMERS];
   logic [cpt_pkg::DATA_W-1:0]     counter_in   [NUM_TIMERS];
   logic [cpt_pkg::DATA_W-1:0]     reload_ff    [NUM_TIMERS];
   logic [cpt_pkg::DATA_W-1:0]     reload_in    [NUM_TIMERS];
   logic [cpt_pkg::PRESCALE_W-1:0] prescale_ff  [NUM_TIMERS];
   logic [cpt_pkg::PRESCALE_W-1:0] prescale_in  [NUM_TIMERS];
   cpt_pkg::ctrl_type              ctrl_ff      [NUM_TIMERS];
   cpt_pkg::ctrl_type              ctrl_in      [NUM_TIMERS];

   always_comb begin
      logic                        carry;
      logic                        step;
      logic                        ovf;
      logic                        sel;
      logic [cpt_pkg::LIMIT_W-1:0] pc;
      cpt_pkg::ctrl_type           cw;
      carry          = 1'b0;
      rsp.read_value = '0;
      rsp.irq_pulses = '0;
      cw.prescale    = req.write_data[1:0];
      cw.cascade     = req.write_data[cpt_pkg::CTRL_CASCADE_BIT];
      cw.irq         = req.write_data[cpt_pkg::CTRL_IRQ_BIT];
      cw.enable      = req.write_data[cpt_pkg::CTRL_ENABLE_BIT];
      for (int i = 0; i < NUM_TIMERS; i++) begin
         counter_in[i]  = counter_ff[i];
         reload_in[i]   = reload_ff[i];
         prescale_in[i] = prescale_ff[i];
         ctrl_in[i]     = ctrl_ff[i];
         sel  = (int'(req.timer_index) == i);
         step = 1'b0;
         ovf  = 1'b0;
         pc   = {1'b0, prescale_ff[i]} + cpt_pkg::LIMIT_W'(1);
         if (go) begin
            unique case (req.mode)
               cpt_pkg::MODE_TICK: begin
                  if (ctrl_ff[i].enable) begin
                     if (ctrl_ff[i].cascade) begin
                        step = carry;
                     end else if (pc >= cpt_pkg::prescale_limit(ctrl_ff[i].prescale)) begin
                        prescale_in[i] = '0;
                        step           = 1'b1;
                     end else begin
                        prescale_in[i] = pc[cpt_pkg::PRESCALE_W-1:0];
                     end
                  end
                  if (step) begin
                     if (counter_ff[i] == cpt_pkg::COUNT_MAX) begin
                        ovf           = 1'b1;
                        counter_in[i] = reload_ff[i];
                     end else begin
                        counter_in[i] = counter_ff[i] + cpt_pkg::DATA_W'(1);
                     end
                  end
                  if (i < IrqBits) begin
                     rsp.irq_pulses[i[1:0]] = ovf & ctrl_ff[i].irq;
                  end
               end
               cpt_pkg::MODE_CONTROL: begin
                  if (sel) begin
                     ctrl_in[i]     = cw;
                     prescale_in[i] = '0;
                     if (!ctrl_ff[i].enable && cw.enable) begin
                        counter_in[i] = reload_ff[i];
                     end
                  end
               end
               cpt_pkg::MODE_RELOAD: begin
                  if (sel) begin
                     reload_in[i] = req.write_data;
                  end
               end
               cpt_pkg::MODE_READ: begin
                  if (sel) begin
                     rsp.read_value = counter_ff[i];
                  end
               end
               default: begin
               end
            endcase
         end
         carry = ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TIMERS; i++) begin
            counter_ff[i]  <= '0;
            reload_ff[i]   <= '0;
            prescale_ff[i] <= '0;
            ctrl_ff[i]     <= '0;
         end
      end else begin
         for (int i = 0; i < NUM_TIMERS; i++) begin
            counter_ff[i]  <= counter_in[i];
            reload_ff[i]   <= reload_in[i];
            prescale_ff[i] <= prescale_in[i];
            ctrl_ff[i]     <= ctrl_in[i];
         end
      end
   end

endmodule

FILE: design/cascaded_prescaled_timer_bank_top.sv
// ----------------------------------------------------------------------------
// cascaded_prescaled_timer_bank_top
// Bank of 16-bit up-counting timers with prescaler, cascade and IRQ pulses.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the req_ stream: req_tuser carries the mode (tick,
//   control write, reload write, counter read), req_tdata the timer index
//   and write data. Every request yields exactly one response on rsp_:
//   the counter on a read, the IRQ pulse bits on a tick, zero otherwise.
//   A request is registered in the input register on acceptance and processed
//   in one pass into the response register, which drives rsp_tvalid.
//   One request per cycle is sustained while rsp_tready stays high; the cycle
//   is set by the cascade carry rippling through all timers in one pass.
//   Reset clears all counters, reloads, prescalers and controls, so every
//   timer starts disabled, and empties both registers.
//   When the receiver stalls, the response holds; one more request may sit
//   in the input register, after which req_tready drops until rsp_tready
//   frees the response register.
// ----------------------------------------------------------------------------
module cascaded_prescaled_timer_bank_top #(
   parameter int NUM_TIMERS = cpt_pkg::NUM_TIMERS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // timer_index[1:0], write_data[17:2], zero pad
   input  logic [1:0]  req_tuser,   // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // read_value[15:0], irq_pulses[19:16], zero pad
);

   logic             req_valid_ff;
   logic             req_valid_in;
   cpt_pkg::req_type req_ff;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   cpt_pkg::rsp_type rsp_ff;
   cpt_pkg::rsp_type rsp_in;
   logic             advance;
   logic             accept;

   assign advance      = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready   = !req_valid_ff || advance;
   assign accept       = req_tvalid && req_tready;
   assign req_valid_in = accept || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   cpt_bank #(
      .NUM_TIMERS(NUM_TIMERS)
   ) u_bank (
      .clock(clock),
      .reset(reset),
      .go   (advance),
      .req  (req_ff),
      .rsp  (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff.mode        <= cpt_pkg::mode_type'(req_tuser);
         req_ff.timer_index <= req_tdata[1:0];
         req_ff.write_data  <= req_tdata[17:2];
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_ff.irq_pulses, rsp_ff.read_value};

`ifndef NO_ASSERTIONS
   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed request did not reach the response register");

   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> req_valid_ff && rsp_valid_ff && !rsp_tready)
      else $error("input blocked without a stalled response");

   a_irq_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      advance && req_ff.mode != cpt_pkg::MODE_TICK |=> rsp_ff.irq_pulses == '0)
      else $error("irq pulses on a non-tick request");

   a_read_only_on_read: assert property (@(posedge clock) disable iff (reset)
      advance && req_ff.mode != cpt_pkg::MODE_READ |=> rsp_ff.read_value == '0)
      else $error("read value on a non-read request");
`endif

endmodule
